// ===== sv/ookpw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ookpw_pkg
// Shared types, codes and reset values of the OOK pulse-width frame encoder.
// ----------------------------------------------------------------------------
package ookpw_pkg;

    localparam int C_MAX_BYTES = 16;

    localparam logic [15:0] C_ZERO_HALF_RST = 16'd400;
    localparam logic [15:0] C_ONE_HALF_RST  = 16'd600;
    localparam logic [19:0] C_GAP_RST       = 20'd10000;
    localparam logic [7:0]  C_REPEAT_RST    = 8'd10;
    localparam logic [5:0]  C_PREAMBLE_RST  = 6'd24;
    localparam logic        C_APPEND_RST    = 1'b0;
    localparam logic [7:0]  C_OFFSET_RST    = 8'd6;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_START = 2'd1,
        ACT_TICK  = 2'd2
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ZERO_HALF = 3'd0,
        CFG_ONE_HALF  = 3'd1,
        CFG_GAP       = 3'd2,
        CFG_REPEAT    = 3'd3,
        CFG_PREAMBLE  = 3'd4,
        CFG_APPEND    = 3'd5,
        CFG_OFFSET    = 3'd6
    } t_cfg_idx;

    typedef enum logic [6:0] {
        PH_IDLE   = 7'b0000001,
        PH_PRE    = 7'b0000010,
        PH_SYNC   = 7'b0000100,
        PH_DATA   = 7'b0001000,
        PH_PARITY = 7'b0010000,
        PH_TRAIL  = 7'b0100000,
        PH_GAP    = 7'b1000000
    } t_phase;

    typedef struct packed {
        logic [15:0] zero_half;
        logic [15:0] one_half;
        logic [19:0] gap;
        logic [7:0]  repeat_cnt;
        logic [5:0]  preamble;
        logic        append_cksum;
        logic [7:0]  cksum_offset;
    } t_cfg;

    typedef struct packed {
        logic pin_level;
        logic busy_res;
        logic frame_done;
        logic load_rejected;
    } t_res;

endpackage

// ===== sv/ookpw_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ookpw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ookpw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/ookpw_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ookpw_cfg
// Configuration register file: timing, repeat and checksum settings.
// ----------------------------------------------------------------------------
module ookpw_cfg
    import ookpw_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                CFG_ZERO_HALF: n_cfg.zero_half    = i_cfg_data[15:0];
                CFG_ONE_HALF:  n_cfg.one_half     = i_cfg_data[15:0];
                CFG_GAP:       n_cfg.gap          = i_cfg_data[19:0];
                CFG_REPEAT:    n_cfg.repeat_cnt   = i_cfg_data[7:0];
                CFG_PREAMBLE:  n_cfg.preamble     = i_cfg_data[5:0];
                CFG_APPEND:    n_cfg.append_cksum = i_cfg_data[0];
                CFG_OFFSET:    n_cfg.cksum_offset = i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.zero_half    <= C_ZERO_HALF_RST;
            r_cfg.one_half     <= C_ONE_HALF_RST;
            r_cfg.gap          <= C_GAP_RST;
            r_cfg.repeat_cnt   <= C_REPEAT_RST;
            r_cfg.preamble     <= C_PREAMBLE_RST;
            r_cfg.append_cksum <= C_APPEND_RST;
            r_cfg.cksum_offset <= C_OFFSET_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== sv/ookpw_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ookpw_core
// Frame sequencer: byte buffer, bit/phase counters and pin level per request.
// ----------------------------------------------------------------------------
module ookpw_core
    import ookpw_pkg::*;
#(
    parameter int MAX_BYTES = C_MAX_BYTES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_go,
    input  logic [1:0] i_action,
    input  logic [7:0] i_data_byte,
    input  t_cfg       i_cfg,
    output t_res       o_res
);

    localparam int IW = $clog2(MAX_BYTES + 2);
    localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

    function automatic logic [19:0] f_half(input logic b, input t_cfg c);
        logic [15:0] h;
        h = b ? c.one_half : c.zero_half;
        return (h == 16'd0) ? 20'd1 : {4'd0, h};
    endfunction

    t_phase        r_phase, n_phase;
    logic [5:0]    r_bit_cnt, n_bit_cnt;
    logic [IW-1:0] r_byte_idx, n_byte_idx;
    logic [IW-1:0] r_byte_cnt, n_byte_cnt;
    logic [7:0]    r_byte_sum, n_byte_sum;
    logic          r_second, n_second;
    logic [19:0]   r_tick_left, n_tick_left;
    logic [7:0]    r_rep_left, n_rep_left;
    logic          r_parity, n_parity;
    logic          r_cur_bit, n_cur_bit;
    logic [7:0]    r_cur_byte, n_cur_byte;
    logic          r_cur_ck, n_cur_ck;

    logic [7:0]    w_rdata;
    logic [7:0]    w_cksum;
    logic [7:0]    w_cur_val;
    logic [7:0]    w_start_val;
    logic [IW-1:0] w_fetch_idx;
    logic [IW-1:0] w_start_idx;
    logic [IW-1:0] w_total;
    logic [19:0]   w_tl;
    logic [5:0]    w_bc_dec;
    logic          w_we;
    logic          w_rej;
    logic          w_done;
    logic          w_end_rep;
    logic          w_begin_rep;
    logic          w_start;
    logic          w_bit_go;
    t_phase        w_bit_ph;
    logic          w_bit_val;
    logic          w_stored;
    logic          w_pin;

    // Prefetch: next byte index while a byte is going out, else current index.
    assign w_fetch_idx = (r_phase inside {PH_DATA, PH_PARITY}) ? r_byte_idx + IW'(1)
                                                                : r_byte_idx;

    ookpw_ram #(
        .WIDTH (8),
        .DEPTH (MAX_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_byte_cnt[AW-1:0]),
        .i_wdata (i_data_byte),
        .i_raddr (w_fetch_idx[AW-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_cksum   = r_byte_sum + i_cfg.cksum_offset;
    assign w_cur_val = r_cur_ck ? w_cksum : r_cur_byte;
    assign w_total   = r_byte_cnt + IW'(i_cfg.append_cksum);
    assign w_bc_dec  = r_bit_cnt - 6'd1;

    always_comb begin
        n_phase     = r_phase;
        n_bit_cnt   = r_bit_cnt;
        n_byte_idx  = r_byte_idx;
        n_byte_cnt  = r_byte_cnt;
        n_byte_sum  = r_byte_sum;
        n_second    = r_second;
        n_tick_left = r_tick_left;
        n_rep_left  = r_rep_left;
        n_parity    = r_parity;
        n_cur_bit   = r_cur_bit;
        n_cur_byte  = r_cur_byte;
        n_cur_ck    = r_cur_ck;
        w_we        = 1'b0;
        w_rej       = 1'b0;
        w_done      = 1'b0;
        w_end_rep   = 1'b0;
        w_begin_rep = 1'b0;
        w_start     = 1'b0;
        w_start_idx = r_byte_idx;
        w_bit_go    = 1'b0;
        w_bit_ph    = r_phase;
        w_bit_val   = 1'b0;
        w_tl        = r_tick_left;
        w_stored    = 1'b0;
        w_start_val = w_rdata;

        case (i_action)
            ACT_LOAD: begin
                if (r_phase != PH_IDLE || r_byte_cnt >= IW'(MAX_BYTES)) begin
                    w_rej = 1'b1;
                end else begin
                    w_we       = i_go;
                    n_byte_cnt = r_byte_cnt + IW'(1);
                    n_byte_sum = r_byte_sum + i_data_byte;
                end
            end
            ACT_START: begin
                if (r_phase == PH_IDLE) begin
                    n_rep_left  = (i_cfg.repeat_cnt == 8'd0) ? 8'd1 : i_cfg.repeat_cnt;
                    w_begin_rep = 1'b1;
                end
            end
            ACT_TICK: begin
                if (r_phase != PH_IDLE) begin
                    w_tl        = (r_tick_left != 20'd0) ? r_tick_left - 20'd1 : 20'd0;
                    n_tick_left = w_tl;
                    if (w_tl == 20'd0) begin
                        if (r_phase == PH_GAP) begin
                            w_end_rep = 1'b1;
                        end else if (!r_second) begin
                            n_second    = 1'b1;
                            n_tick_left = f_half(r_cur_bit, i_cfg);
                        end else begin
                            case (r_phase)
                                PH_PRE: begin
                                    n_bit_cnt = w_bc_dec;
                                    w_bit_go  = 1'b1;
                                    if (w_bc_dec != 6'd0) begin
                                        w_bit_ph  = PH_PRE;
                                        w_bit_val = 1'b0;
                                    end else begin
                                        w_bit_ph  = PH_SYNC;
                                        w_bit_val = 1'b1;
                                    end
                                end
                                PH_SYNC: begin
                                    w_start = 1'b1;
                                end
                                PH_DATA: begin
                                    n_parity = r_parity ^ r_cur_bit;
                                    w_bit_go = 1'b1;
                                    if (r_bit_cnt != 6'd0) begin
                                        n_bit_cnt = w_bc_dec;
                                        w_bit_ph  = PH_DATA;
                                        w_bit_val = w_cur_val[w_bc_dec[2:0]];
                                    end else begin
                                        w_bit_ph  = PH_PARITY;
                                        w_bit_val = r_parity ^ r_cur_bit;
                                    end
                                end
                                PH_PARITY: begin
                                    n_byte_idx  = r_byte_idx + IW'(1);
                                    w_start_idx = r_byte_idx + IW'(1);
                                    w_start     = 1'b1;
                                end
                                default: begin
                                    if (i_cfg.gap != 20'd0) begin
                                        n_phase     = PH_GAP;
                                        n_second    = 1'b0;
                                        n_tick_left = i_cfg.gap;
                                    end else begin
                                        w_end_rep = 1'b1;
                                    end
                                end
                            endcase
                        end
                    end
                end
            end
            default: ;
        endcase

        if (w_end_rep) begin
            n_rep_left = r_rep_left - 8'd1;
            if (n_rep_left == 8'd0) begin
                n_phase     = PH_IDLE;
                n_second    = 1'b0;
                n_tick_left = 20'd0;
                n_bit_cnt   = 6'd0;
                n_byte_idx  = '0;
                n_parity    = 1'b0;
                n_cur_bit   = 1'b0;
                n_byte_cnt  = '0;
                n_byte_sum  = 8'd0;
                w_done      = 1'b1;
            end else begin
                w_begin_rep = 1'b1;
            end
        end

        if (w_begin_rep) begin
            n_byte_idx = '0;
            w_bit_go   = 1'b1;
            if (i_cfg.preamble != 6'd0) begin
                n_bit_cnt = i_cfg.preamble;
                w_bit_ph  = PH_PRE;
                w_bit_val = 1'b0;
            end else begin
                w_bit_ph  = PH_SYNC;
                w_bit_val = 1'b1;
            end
        end

        if (w_start) begin
            w_bit_go = 1'b1;
            if (w_start_idx < w_total) begin
                w_stored    = (w_start_idx < r_byte_cnt);
                w_start_val = w_stored ? w_rdata : w_cksum;
                n_bit_cnt   = 6'd7;
                n_parity    = 1'b0;
                n_cur_byte  = w_rdata;
                n_cur_ck    = !w_stored;
                w_bit_ph    = PH_DATA;
                w_bit_val   = w_start_val[7];
            end else begin
                w_bit_ph  = PH_TRAIL;
                w_bit_val = 1'b0;
            end
        end

        if (w_bit_go) begin
            n_phase     = w_bit_ph;
            n_cur_bit   = w_bit_val;
            n_second    = 1'b0;
            n_tick_left = f_half(w_bit_val, i_cfg);
        end
    end

    // Tick: level driven during the tick; other actions: level after the update.
    always_comb begin
        if (i_action == ACT_TICK) begin
            w_pin = !(r_phase inside {PH_IDLE, PH_GAP}) && !r_second;
        end else begin
            w_pin = !(n_phase inside {PH_IDLE, PH_GAP}) && !n_second;
        end
    end

    assign o_res.pin_level     = w_pin;
    assign o_res.busy_res      = (n_phase != PH_IDLE);
    assign o_res.frame_done    = w_done;
    assign o_res.load_rejected = w_rej;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_bit_cnt   <= 6'd0;
            r_byte_idx  <= '0;
            r_byte_cnt  <= '0;
            r_byte_sum  <= 8'd0;
            r_second    <= 1'b0;
            r_tick_left <= 20'd0;
            r_rep_left  <= 8'd0;
            r_parity    <= 1'b0;
            r_cur_bit   <= 1'b0;
            r_cur_ck    <= 1'b0;
        end else if (i_go) begin
            r_phase     <= n_phase;
            r_bit_cnt   <= n_bit_cnt;
            r_byte_idx  <= n_byte_idx;
            r_byte_cnt  <= n_byte_cnt;
            r_byte_sum  <= n_byte_sum;
            r_second    <= n_second;
            r_tick_left <= n_tick_left;
            r_rep_left  <= n_rep_left;
            r_parity    <= n_parity;
            r_cur_bit   <= n_cur_bit;
            r_cur_ck    <= n_cur_ck;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_cur_byte <= n_cur_byte;
        end
    end

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && o_res.frame_done) |=> (r_phase == PH_IDLE && r_byte_cnt == '0))
        else $error("frame end did not return to idle with empty buffer");

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_phase == PH_IDLE && r_byte_cnt < IW'(MAX_BYTES)))
        else $error("buffer written while busy or full");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_cnt <= IW'(MAX_BYTES))
        else $error("byte count beyond capacity");

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && i_action == ACT_START && r_phase == PH_IDLE)
            |=> (r_phase == PH_PRE || r_phase == PH_SYNC))
        else $error("start did not enter preamble or sync");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_byte_idx < w_total && r_bit_cnt <= 6'd7))
        else $error("data phase past frame end");

endmodule

// ===== sv/ook_pulse_width_frame_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ook_pulse_width_frame_encoder
// OOK pulse-width frame encoder: byte buffer, repeats, parity and checksum.
// ----------------------------------------------------------------------------
// Channel   Handshake            Payload
// input     i_valid / o_ready    i_action, i_data_byte
// result    o_valid / i_ready    o_pin_level, o_busy_res, o_frame_done,
//                                o_load_rejected
// config    i_cfg_wr_en          i_cfg_idx, i_cfg_data
//
// One request per clock if o_ready; its result is registered the next cycle.
// The sequencer state updates in the accepting cycle from one pass of logic.
// o_ready drops only while a result is held and i_ready is low.
// Synchronous active-low reset clears state and loads register defaults.
// ----------------------------------------------------------------------------
module ook_pulse_width_frame_encoder
    import ookpw_pkg::*;
#(
    parameter int MAX_BYTES = C_MAX_BYTES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [1:0]            i_action,
    input  logic [7:0]            i_data_byte,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_pin_level,
    output logic                  o_busy_res,
    output logic                  o_frame_done,
    output logic                  o_load_rejected,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg w_cfg;
    t_res w_res;
    t_res r_res;
    logic r_out_valid;
    logic w_go;

    assign o_ready = !r_out_valid || i_ready;
    assign w_go    = i_valid && o_ready;

    ookpw_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    ookpw_core #(
        .MAX_BYTES (MAX_BYTES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (w_go),
        .i_action    (i_action),
        .i_data_byte (i_data_byte),
        .i_cfg       (w_cfg),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_go) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_res <= w_res;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_pin_level     = r_res.pin_level;
    assign o_busy_res      = r_res.busy_res;
    assign o_frame_done    = r_res.frame_done;
    assign o_load_rejected = r_res.load_rejected;

endmodule
